/* rtl/core/msp_rx_pkg.sv */
// Shared constants and types for the MSP v1 frame receiver.
// No dependencies; the front end, queue, back end and top level import this package.
package msp_rx_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int PAY_DEPTH   = 64;
  localparam int PAY_AW      = $clog2(PAY_DEPTH);
  localparam int IDLE_W      = 17;
  localparam int TIMEOUT_W   = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd25000;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_GT     = 8'h3E;

  typedef struct packed {
    logic       ok;
    logic [7:0] command;
    logic [5:0] size;
  } frame_desc_t;

  typedef struct packed {
    logic              en;
    logic [PAY_AW-1:0] addr;
    logic [7:0]        data;
  } pay_wr_t;

endpackage

/* rtl/core/msp_rx_ifs.sv */
// Channel interfaces for the MSP v1 frame receiver: input words,
// result words and the timeout register write. No dependencies.
interface msp_item_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  modport source (output valid, opcode, data_byte, input ready);
  modport sink (input valid, opcode, data_byte, output ready);
endinterface

interface msp_result_if;
  logic       valid;
  logic       ready;
  logic       frame_ok;
  logic [7:0] command;
  logic [5:0] payload_size;
  logic [5:0] payload_index;
  logic [7:0] payload_byte;
  logic       last;
  modport source (output valid, frame_ok, command, payload_size, payload_index,
                  payload_byte, last, input ready);
  modport sink (input valid, frame_ok, command, payload_size, payload_index,
                payload_byte, last, output ready);
endinterface

interface msp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;
  modport source (output valid, timeout_ticks, input ready);
  modport sink (input valid, timeout_ticks, output ready);
endinterface

/* rtl/core/msp_rx_front.sv */
// Front end: accepts input words, tracks header state, idle timeout and
// checksum, writes payload bytes and pushes frame descriptors. Uses msp_rx_pkg.
module msp_rx_front
  import msp_rx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  msp_item_if.sink          items,
  msp_cfg_if.sink           cfg,
  input  logic              readout_busy,
  output pay_wr_t           pay_wr,
  output logic              desc_push,
  output frame_desc_t       desc
);

  typedef enum logic [2:0] {
    HDR_DOLLAR, HDR_M, HDR_DIR, HDR_SIZE, HDR_CMD, HDR_DATA
  } hdr_t;

  hdr_t                 hdr;
  logic [5:0]           count;
  logic [5:0]           size;
  logic [7:0]           cmd;
  logic [7:0]           csum;
  logic [IDLE_W-1:0]    idle;
  logic [TIMEOUT_W-1:0] timeout;

  logic is_byte, accept, byte_acc, timed_out;
  logic [7:0] c;

  assign is_byte   = (items.opcode == OP_BYTE);
  assign c         = items.data_byte;
  assign items.ready = !(is_byte && hdr == HDR_DATA && readout_busy);
  assign accept    = items.valid && items.ready;
  assign byte_acc  = accept && is_byte;
  assign timed_out = (hdr != HDR_DOLLAR) && (idle > {1'b0, timeout});
  assign cfg.ready = 1'b1;

  always_comb begin
    pay_wr.en   = byte_acc && !timed_out && hdr == HDR_DATA && count < size;
    pay_wr.addr = PAY_AW'(count);
    pay_wr.data = c;
    desc_push   = byte_acc && !timed_out && hdr == HDR_DATA && count >= size;
    desc.ok      = (csum == c);
    desc.command = cmd;
    desc.size    = size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr     <= HDR_DOLLAR;
      count   <= '0;
      size    <= '0;
      cmd     <= '0;
      csum    <= '0;
      idle    <= '0;
      timeout <= TIMEOUT_RESET;
    end else begin
      if (cfg.valid) begin
        timeout <= cfg.timeout_ticks;
      end
      if (accept && !is_byte) begin
        if (idle != '1) begin
          idle <= idle + 1'b1;
        end
      end else if (byte_acc) begin
        idle <= '0;
        if (timed_out) begin
          hdr   <= HDR_DOLLAR;
          count <= '0;
        end else begin
          case (hdr)
            HDR_DOLLAR: begin
              hdr <= (c == CH_DOLLAR) ? HDR_M : HDR_DOLLAR;
              count <= '0;
            end
            HDR_M: begin
              hdr <= (c == CH_M) ? HDR_DIR : HDR_DOLLAR;
              count <= '0;
            end
            HDR_DIR: begin
              hdr <= (c == CH_GT) ? HDR_SIZE : HDR_DOLLAR;
              count <= '0;
            end
            HDR_SIZE: begin
              count <= '0;
              if (c < 8'(MAX_PAYLOAD)) begin
                size <= c[5:0];
                csum <= c;
                hdr  <= HDR_CMD;
              end else begin
                hdr <= HDR_DOLLAR;
              end
            end
            HDR_CMD: begin
              cmd  <= c;
              csum <= csum ^ c;
              hdr  <= HDR_DATA;
            end
            HDR_DATA: begin
              if (count < size) begin
                csum  <= csum ^ c;
                count <= count + 1'b1;
              end else begin
                hdr   <= HDR_DOLLAR;
                count <= '0;
              end
            end
            default: begin
              hdr   <= HDR_DOLLAR;
              count <= '0;
            end
          endcase
        end
      end
    end
  end

endmodule

/* rtl/core/msp_rx_fifo.sv */
// Two-entry queue of completed frame descriptors between front and back.
// Uses msp_rx_pkg.
module msp_rx_fifo
  import msp_rx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  frame_desc_t push_data,
  input  logic        pop,
  output logic        empty,
  output frame_desc_t head
);

  frame_desc_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign empty = (fill == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && fill != 2'd2) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && fill != 2'd2) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push && fill != 2'd2} - {1'b0, pop && !empty};
    end
  end

endmodule

/* rtl/core/msp_rx_back.sv */
// Back end: holds the payload memory, takes frame descriptors and reads
// each frame out as a run of result words. Uses msp_rx_pkg.
module msp_rx_back
  import msp_rx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  pay_wr_t     pay_wr,
  input  logic        desc_empty,
  input  frame_desc_t desc_head,
  output logic        desc_pop,
  output logic        busy,
  msp_result_if.source results
);

  logic [7:0] mem [PAY_DEPTH];

  frame_desc_t cur;
  logic [5:0]  k;

  logic        s1_valid;
  frame_desc_t s1_desc;
  logic [5:0]  s1_idx;
  logic        s1_last;
  logic        s1_zero;
  logic [7:0]  mem_q;

  logic out_valid;
  logic out_load, s1_ready, issue, zero_now, last_now;

  assign out_load = s1_valid && (!out_valid || results.ready);
  assign s1_ready = !s1_valid || out_load;
  assign issue    = busy && s1_ready;
  assign zero_now = !cur.ok || cur.size == '0;
  assign last_now = zero_now || (k == cur.size - 1'b1);
  assign desc_pop = !busy && !desc_empty;
  assign results.valid = out_valid;

  always_ff @(posedge clk) begin
    if (pay_wr.en) begin
      mem[pay_wr.addr] <= pay_wr.data;
    end
    if (issue) begin
      mem_q <= mem[PAY_AW'(k)];
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      cur <= desc_head;
    end
    if (issue) begin
      s1_desc <= cur;
      s1_idx  <= k;
      s1_last <= last_now;
      s1_zero <= zero_now;
    end
    if (out_load) begin
      results.frame_ok      <= s1_desc.ok;
      results.command       <= s1_desc.command;
      results.payload_size  <= s1_desc.size;
      results.payload_index <= s1_idx;
      results.payload_byte  <= s1_zero ? 8'd0 : mem_q;
      results.last          <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      k         <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (desc_pop) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (issue) begin
        k <= k + 1'b1;
        if (last_now) begin
          busy <= 1'b0;
        end
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/msp_frame_receiver.sv */
// Top level of the MSP v1 frame receiver: front end, descriptor queue and
// readout back end. Uses msp_rx_pkg and the channel interfaces.
//
//   channel  | dir | words
//   items    | in  | opcode, data_byte (byte or idle tick)
//   results  | out | frame_ok, command, payload_size, payload_index, payload_byte, last
//   cfg      | in  | timeout_ticks, always ready
//
// One input word is taken per cycle. A byte that arrives in the payload state
// waits while the previous frame is read out: its descriptor is fetched, then each
// result word is read from the payload memory read port. A frame's results follow
// its checksum byte through the queue, current descriptor register and read stage,
// then come one per cycle; a stalled result port holds the readout. Synchronous
// reset clears the parser, idle counter, queue and readout, not the payload memory.
module msp_frame_receiver
  import msp_rx_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  msp_item_if.sink     items,
  msp_cfg_if.sink      cfg,
  msp_result_if.source results
);

  pay_wr_t     pay_wr;
  logic        desc_push;
  frame_desc_t desc;
  logic        desc_pop;
  logic        desc_empty;
  frame_desc_t desc_head;
  logic        back_busy;
  logic        readout_busy;

  assign readout_busy = !desc_empty || back_busy;

  msp_rx_front u_front (
    .clk          (clk),
    .rst          (rst),
    .items        (items),
    .cfg          (cfg),
    .readout_busy (readout_busy),
    .pay_wr       (pay_wr),
    .desc_push    (desc_push),
    .desc         (desc)
  );

  msp_rx_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_push),
    .push_data (desc),
    .pop       (desc_pop),
    .empty     (desc_empty),
    .head      (desc_head)
  );

  msp_rx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pay_wr     (pay_wr),
    .desc_empty (desc_empty),
    .desc_head  (desc_head),
    .desc_pop   (desc_pop),
    .busy       (back_busy),
    .results    (results)
  );

endmodule
